FILE: rtl/ppu_pkg.sv
`timescale 1ns / 1ps
package ppu_pkg;

   localparam int SLOTS_DEF = 64;
   localparam int NKINDS = 27;
   localparam int POS_W = 32;
   localparam int VEL_W = 24;
   localparam int AGE_W = 9;
   localparam int KIND_W = 5;
   localparam int CAP_W = 7;
   localparam int DRAG_MUL = 64225;

   localparam logic [0:0] REQ_SPAWN = 1'b0;
   localparam logic [0:0] REQ_TICK = 1'b1;

   localparam logic [0:0] CSR_ENABLE = 1'b0;
   localparam logic [0:0] CSR_MAX_ACTIVE = 1'b1;

   // One queued request between the front and the back.
   typedef struct packed {
      logic             is_tick;
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
      logic [VEL_W-1:0]  vx;
      logic [VEL_W-1:0]  vy;
      logic [VEL_W-1:0]  vz;
   } cmd_type;

   function automatic logic [3:0] kind_frames(input logic [KIND_W-1:0] k);
      logic [3:0] r;
      case (k)
         5'd1: r = 4'd8;   5'd2: r = 4'd12;  5'd3: r = 4'd10;  5'd4: r = 4'd8;
         5'd5: r = 4'd6;   5'd6: r = 4'd4;   5'd7: r = 4'd4;   5'd9: r = 4'd4;
         5'd10: r = 4'd6;  5'd11: r = 4'd8;  5'd12: r = 4'd6;  5'd13: r = 4'd3;
         5'd14: r = 4'd4;  5'd17: r = 4'd4;  5'd19: r = 4'd4;  5'd21: r = 4'd3;
         5'd23: r = 4'd8;  5'd24: r = 4'd12;
         default: r = 4'd1;
      endcase
      return r;
   endfunction

   function automatic logic [AGE_W-1:0] kind_life(input logic [KIND_W-1:0] k);
      logic [AGE_W-1:0] r;
      case (k)
         5'd1: r = 9'd60;   5'd2: r = 9'd120;  5'd3: r = 9'd80;   5'd4: r = 9'd90;
         5'd5: r = 9'd45;   5'd6: r = 9'd40;   5'd7: r = 9'd180;  5'd8: r = 9'd60;
         5'd9: r = 9'd20;   5'd10: r = 9'd50;  5'd11: r = 9'd30;  5'd12: r = 9'd90;
         5'd13: r = 9'd15;  5'd14: r = 9'd35;  5'd15: r = 9'd60;  5'd16: r = 9'd60;
         5'd17: r = 9'd90;  5'd18: r = 9'd180; 5'd19: r = 9'd10;  5'd20: r = 9'd5;
         5'd21: r = 9'd8;   5'd22: r = 9'd300; 5'd23: r = 9'd30;  5'd24: r = 9'd45;
         5'd25: r = 9'd60;  5'd26: r = 9'd45;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [13:0] kind_grav(input logic [KIND_W-1:0] k);
      logic signed [13:0] r;
      case (k)
         5'd1, 5'd10, 5'd23, 5'd24: r = -14'sd1311;
         5'd2, 5'd4, 5'd17: r = -14'sd655;
         5'd3, 5'd15: r = -14'sd1966;
         5'd5: r = -14'sd2621;
         5'd6, 5'd14: r = 14'sd655;
         5'd7, 5'd16: r = 14'sd1311;
         5'd8: r = 14'sd328;
         5'd9: r = 14'sd3277;
         5'd13: r = 14'sd1966;
         5'd18: r = 14'sd983;
         5'd25: r = 14'sd5243;
         5'd26: r = 14'sd3932;
         default: r = 14'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/ppu_ram.sv
`timescale 1ns / 1ps
module ppu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/ppu_front.sv
`timescale 1ns / 1ps
// Front end: takes requests into a two-entry queue. Disabled ticks are
// dropped here since they have no effect and no result.
module ppu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   output logic              in_ready,
   input  ppu_pkg::cmd_type  in_cmd,
   output logic              q_valid,
   input  logic              q_pop,
   output ppu_pkg::cmd_type  q_cmd
);
   ppu_pkg::cmd_type q_ff [2];
   ppu_pkg::cmd_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready && !(in_cmd.is_tick && !enable);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (q_pop && q_valid) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = in_cmd;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTH
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("ready while full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_valid && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("pop lost");
`endif
endmodule

FILE: rtl/ppu_back.sv
`timescale 1ns / 1ps
// Back end: spawn finds the lowest free slot; tick walks every slot and takes
// each live slot through a read, compute and write sequence.
module ppu_back #(
   parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        max_active,
   input  logic              enable,
   input  logic              q_valid,
   output logic              q_pop,
   input  ppu_pkg::cmd_type  q_cmd,
   output logic              o_valid,
   input  logic              o_ready,
   output logic [5:0]        o_slot,
   output logic [4:0]        o_kind,
   output logic [31:0]       o_x,
   output logic [31:0]       o_y,
   output logic [31:0]       o_z,
   output logic [7:0]        o_alpha,
   output logic [3:0]        o_frame,
   output logic              o_ok,
   output logic              o_spawn,
   output logic              o_last
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_RW = 5 + 9 + 9 + 8 + 4;
   localparam int KW = 3 * 32 + 3 * 24;

   typedef enum logic [3:0] {
      S_IDLE, S_SPAWN, S_SCAN, S_READ, S_GRAV, S_DRAG, S_MUL, S_POS,
      S_DIV, S_PEND, S_OUT
   } st_type;

   st_type st_ff;
   logic [SLOTS-1:0] act_ff;
   logic [6:0]       total_ff;
   logic [SW:0]      idx_ff;
   logic [SW-1:0]    pend_slot_ff;
   logic             pend_ff;

   // per-slot data memories
   logic             srw_en, kw_en;
   logic [SW-1:0]    waddr, raddr;
   logic [SLOT_RW-1:0] srw_d, srr_d;
   logic [KW-1:0]    kw_d, kr_d;

   ppu_ram #(.WIDTH(SLOT_RW), .DEPTH(SLOTS)) u_sram (
      .clock(clock), .wr_en(srw_en), .wr_addr(waddr), .wr_data(srw_d),
      .rd_addr(raddr), .rd_data(srr_d));
   ppu_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_kram (
      .clock(clock), .wr_en(kw_en), .wr_addr(waddr), .wr_data(kw_d),
      .rd_addr(raddr), .rd_data(kr_d));

   // working registers for one slot
   logic [4:0]  kind_ff;
   logic [8:0]  age_ff, life_ff;
   logic [7:0]  alpha_ff;
   logic [3:0]  frame_ff;
   logic [31:0] p_ff [3];
   logic signed [23:0] v_ff [3];
   logic signed [40:0] prod_ff [3];
   logic [18:0] num_ff;
   logic [9:0]  quo_ff;
   logic [9:0]  rem_ff;
   logic [4:0]  dcnt_ff;
   logic        fade_ff;

   // Report held back until it is known whether a later slot reports too.
   logic [4:0]  pkind_ff;
   logic [31:0] ppos_ff [3];
   logic [7:0]  palpha_ff;
   logic [3:0]  pframe_ff;

   // output register
   logic        ov_ff, olast_ff, ook_ff, ospawn_ff;
   logic [5:0]  oslot_ff;
   logic [4:0]  okind_ff;
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic [7:0]  oalpha_ff;
   logic [3:0]  oframe_ff;

   assign o_valid = ov_ff;
   assign o_slot = oslot_ff;   assign o_kind = okind_ff;
   assign o_x = ox_ff;         assign o_y = oy_ff;        assign o_z = oz_ff;
   assign o_alpha = oalpha_ff; assign o_frame = oframe_ff;
   assign o_ok = ook_ff;       assign o_spawn = ospawn_ff; assign o_last = olast_ff;

   // lowest free slot
   logic [SW-1:0] free_idx;
   logic          free_any;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_idx = SW'(i);
            free_any = 1'b1;
         end
      end
   end

   logic [4:0] tk;
   assign tk = (kind_ff < 5'(ppu_pkg::NKINDS)) ? kind_ff : 5'd0;
   logic [4:0] qk;
   assign qk = (q_cmd.kind < 5'(ppu_pkg::NKINDS)) ? q_cmd.kind : 5'd0;

   logic out_free;
   assign out_free = !ov_ff || o_ready;
   logic [8:0] age_n;
   assign age_n = srr_d[SLOT_RW-6 -: 9] + 9'd1;

   logic [SW:0] idx_n;
   assign idx_n = idx_ff + 1'b1;
   logic scan_done;
   assign scan_done = (idx_ff == (SW+1)'(SLOTS));

   logic signed [24:0] vy_g;
   assign vy_g = 25'(v_ff[1]) + 25'(ppu_pkg::kind_grav(tk));

   // restoring divider step for 850*(life-age)/life
   logic [10:0] rem_sh;
   assign rem_sh = {rem_ff, num_ff[18]};

   logic [7:0] alpha_new;
   assign alpha_new = fade_ff ? quo_ff[7:0] : alpha_ff;

   logic spawn_go;
   assign spawn_go = enable && (total_ff < max_active) && free_any;

   // A result is loaded into the output register in this cycle.
   logic emit_now;
   assign emit_now = ((st_ff == S_IDLE) && q_valid && !q_cmd.is_tick && out_free
                      && !spawn_go)
                     || (st_ff == S_SPAWN)
                     || ((st_ff == S_OUT) && pend_ff && out_free)
                     || ((st_ff == S_PEND) && out_free);

   assign raddr = idx_ff[SW-1:0];

   always_comb begin
      srw_en = 1'b0;
      kw_en = 1'b0;
      waddr = idx_ff[SW-1:0];
      srw_d = {kind_ff, age_ff, life_ff, alpha_new, frame_ff};
      kw_d = {p_ff[0], p_ff[1], p_ff[2], v_ff[0], v_ff[1], v_ff[2]};
      if (st_ff == S_SPAWN) begin
         srw_en = 1'b1;
         kw_en = 1'b1;
         waddr = free_idx;
         srw_d = {q_cmd.kind, 9'd0, ppu_pkg::kind_life(qk), 8'd255, 4'd0};
         kw_d = {q_cmd.x, q_cmd.y, q_cmd.z, q_cmd.vx, q_cmd.vy, q_cmd.vz};
      end else if (st_ff == S_OUT && (!pend_ff || out_free)) begin
         srw_en = 1'b1;
         kw_en = 1'b1;
      end else if (st_ff == S_READ && (age_n >= srr_d[SLOT_RW-15 -: 9])) begin
         srw_en = 1'b1;
         srw_d = srr_d;
      end
   end

   // An accepted spawn leaves the queue as its slot is written, a refused one
   // with its reply, a tick once the walk is over and its last report is out.
   assign q_pop = ((st_ff == S_IDLE) && q_valid && !q_cmd.is_tick && out_free
                   && !spawn_go)
                  || (st_ff == S_SPAWN)
                  || ((st_ff == S_SCAN) && scan_done && !pend_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         act_ff <= '0;
         total_ff <= '0;
         ov_ff <= 1'b0;
         pend_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         ov_ff <= emit_now || (ov_ff && !o_ready);
         unique case (st_ff)
            S_IDLE: begin
               if (q_valid) begin
                  if (q_cmd.is_tick) begin
                     idx_ff <= '0;
                     pend_ff <= 1'b0;
                     st_ff <= S_SCAN;
                  end else if (out_free) begin
                     if (spawn_go) begin
                        st_ff <= S_SPAWN;
                     end else begin
                        ospawn_ff <= 1'b1;
                        olast_ff <= 1'b1;
                        oalpha_ff <= '0;
                        oframe_ff <= '0;
                        oslot_ff <= '0;
                        okind_ff <= '0;
                        ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
                        ook_ff <= 1'b0;
                     end
                  end
               end
            end
            S_SPAWN: begin
               act_ff[free_idx] <= 1'b1;
               total_ff <= total_ff + 7'd1;
               ospawn_ff <= 1'b1;
               olast_ff <= 1'b1;
               ook_ff <= 1'b1;
               oslot_ff <= 6'(free_idx);
               okind_ff <= q_cmd.kind;
               ox_ff <= q_cmd.x; oy_ff <= q_cmd.y; oz_ff <= q_cmd.z;
               oalpha_ff <= 8'd255;
               oframe_ff <= '0;
               st_ff <= S_IDLE;
            end
            S_SCAN: begin
               if (scan_done) begin
                  if (pend_ff) st_ff <= S_PEND;
                  else st_ff <= S_IDLE;
               end else if (act_ff[idx_ff[SW-1:0]]) begin
                  st_ff <= S_READ;
               end else begin
                  idx_ff <= idx_n;
               end
            end
            S_READ: begin
               {kind_ff, age_ff, life_ff, alpha_ff, frame_ff} <=
                  {srr_d[SLOT_RW-1 -: 5], age_n, srr_d[SLOT_RW-15 -: 9],
                   srr_d[11:0]};
               {p_ff[0], p_ff[1], p_ff[2], v_ff[0], v_ff[1], v_ff[2]} <= kr_d;
               if (age_n >= srr_d[SLOT_RW-15 -: 9]) begin
                  act_ff[idx_ff[SW-1:0]] <= 1'b0;
                  total_ff <= total_ff - 7'd1;
                  idx_ff <= idx_n;
                  st_ff <= S_SCAN;
               end else begin
                  st_ff <= S_GRAV;
               end
            end
            S_GRAV: begin
               if (vy_g > 25'sd8388607) v_ff[1] <= 24'sh7FFFFF;
               else if (vy_g < -25'sd8388608) v_ff[1] <= 24'sh800000;
               else v_ff[1] <= vy_g[23:0];
               fade_ff <= (10'(age_ff) * 4'd10 > 13'(life_ff) * 3'd7);
               num_ff <= 19'(life_ff - age_ff) * 19'd850;
               rem_ff <= '0;
               quo_ff <= '0;
               dcnt_ff <= '0;
               st_ff <= S_DRAG;
            end
            S_DRAG: begin
               for (int j = 0; j < 3; j++) begin
                  prod_ff[j] <= 41'(v_ff[j]) * 41'(ppu_pkg::DRAG_MUL);
               end
               st_ff <= S_MUL;
            end
            S_MUL: begin
               for (int j = 0; j < 3; j++) begin
                  v_ff[j] <= prod_ff[j][39:16];
               end
               st_ff <= S_POS;
            end
            S_POS: begin
               for (int j = 0; j < 3; j++) begin
                  p_ff[j] <= p_ff[j] + 32'(v_ff[j]);
               end
               // The frame steps once every four ticks and wraps at the
               // kind's frame count.
               if ((ppu_pkg::kind_frames(tk) > 4'd1) && (age_ff[1:0] == 2'b00)) begin
                  if (frame_ff == ppu_pkg::kind_frames(tk) - 4'd1) frame_ff <= '0;
                  else frame_ff <= frame_ff + 4'd1;
               end
               st_ff <= S_DIV;
            end
            S_DIV: begin
               // One quotient bit per cycle, over all 19 bits of the numerator.
               num_ff <= {num_ff[17:0], 1'b0};
               if (rem_sh >= 11'(life_ff)) begin
                  rem_ff <= 10'(rem_sh - 11'(life_ff));
                  quo_ff <= {quo_ff[8:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[9:0];
                  quo_ff <= {quo_ff[8:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd18) begin
                  st_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     ospawn_ff <= 1'b0;
                     ook_ff <= 1'b0;
                     olast_ff <= 1'b0;
                     oslot_ff <= 6'(pend_slot_ff);
                     okind_ff <= pkind_ff;
                     ox_ff <= ppos_ff[0]; oy_ff <= ppos_ff[1]; oz_ff <= ppos_ff[2];
                     oalpha_ff <= palpha_ff;
                     oframe_ff <= pframe_ff;
                  end
                  pend_ff <= 1'b1;
                  pend_slot_ff <= idx_ff[SW-1:0];
                  pkind_ff <= kind_ff;
                  ppos_ff <= p_ff;
                  palpha_ff <= alpha_new;
                  pframe_ff <= frame_ff;
                  idx_ff <= idx_n;
                  st_ff <= S_SCAN;
               end
            end
            S_PEND: begin
               if (out_free) begin
                  ospawn_ff <= 1'b0;
                  ook_ff <= 1'b0;
                  oslot_ff <= 6'(pend_slot_ff);
                  okind_ff <= pkind_ff;
                  ox_ff <= ppos_ff[0]; oy_ff <= ppos_ff[1]; oz_ff <= ppos_ff[2];
                  oalpha_ff <= palpha_ff;
                  oframe_ff <= pframe_ff;
                  olast_ff <= scan_done;
                  pend_ff <= 1'b0;
                  st_ff <= S_SCAN;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff == 7'($countones(act_ff))) else $error("active count mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !o_ready) |=> ov_ff) else $error("result dropped");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_SPAWN |-> !act_ff[free_idx]) else $error("spawn on live slot");
`endif
endmodule

FILE: rtl/particle_pool_update_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Contents
// req_    | in        | tuser: req_type; tdata: kind, x, y, z, vx, vy, vz
// rsp_    | out       | tuser: spawn_ok, is_spawn_reply; tdata: slot..frame; tlast
// csr_    | in        | write enable, index, data (enable, max_active)
//
// A refused spawn is answered from the idle state, an accepted one through the
// spawn state that writes its slot. A tick visits every slot: a free slot is
// only scanned, a slot that dies is read and cleared, and a live slot goes
// through gravity, drag, position and the bit-serial alpha divider.
// Reset is synchronous and clears the active bits and the count; the slot
// memories are not cleared. A two-entry queue lets the requester run ahead
// of the update engine, and one output register holds a result under stall.
module particle_pool_update_unit #(
   parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // req_type
   input  logic [175:0] req_tdata,   // kind[4:0], x, y, z, vx, vy, vz, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // spawn_ok, is_spawn_reply
   output logic [119:0] rsp_tdata,   // slot, kind_out, x, y, z, alpha, frame, zero
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [6:0]   csr_wdata
);
   logic       enable_ff;
   logic [6:0] max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         max_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            ppu_pkg::CSR_ENABLE: enable_ff <= csr_wdata[0];
            ppu_pkg::CSR_MAX_ACTIVE: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ppu_pkg::cmd_type in_cmd, q_cmd;
   assign in_cmd.is_tick = req_tuser[0];
   assign in_cmd.kind = req_tdata[4:0];
   assign in_cmd.x = req_tdata[36:5];
   assign in_cmd.y = req_tdata[68:37];
   assign in_cmd.z = req_tdata[100:69];
   assign in_cmd.vx = req_tdata[124:101];
   assign in_cmd.vy = req_tdata[148:125];
   assign in_cmd.vz = req_tdata[172:149];

   logic q_valid, q_pop;

   ppu_front u_front (
      .clock(clock), .reset(reset), .enable(enable_ff),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

   logic [5:0]  o_slot;
   logic [4:0]  o_kind;
   logic [31:0] o_x, o_y, o_z;
   logic [7:0]  o_alpha;
   logic [3:0]  o_frame;
   logic        o_ok, o_spawn;

   ppu_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset), .max_active(max_ff), .enable(enable_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
      .o_valid(rsp_tvalid), .o_ready(rsp_tready), .o_slot(o_slot),
      .o_kind(o_kind), .o_x(o_x), .o_y(o_y), .o_z(o_z), .o_alpha(o_alpha),
      .o_frame(o_frame), .o_ok(o_ok), .o_spawn(o_spawn), .o_last(rsp_tlast));

   assign rsp_tuser = {o_spawn, o_ok};
   assign rsp_tdata = {1'b0, o_frame, o_alpha, o_z, o_y, o_x, o_kind, o_slot};
endmodule

FILE: dv/tb_particle_pool_update_unit.sv
`timescale 1ns / 1ps
// Testbench for the particle pool update unit.

// One expected or observed result transaction, field by field.
typedef struct {
   logic [5:0]  slot;
   logic [4:0]  kind;
   logic [31:0] x;
   logic [31:0] y;
   logic [31:0] z;
   logic [7:0]  alpha;
   logic [3:0]  frame;
   logic        ok;
   logic        spawn_reply;
   logic        last;
} particle_report_type;

// Mirrors the pool state and keeps the queue of reports that the block owes us.
class particle_pool_scoreboard;
   int frames_tab[27] = '{1, 8, 12, 10, 8, 6, 4, 4, 1, 4, 6, 8, 6, 3, 4, 1, 1, 4, 1, 4,
                          1, 3, 1, 8, 12, 1, 1};
   int life_tab[27] = '{0, 60, 120, 80, 90, 45, 40, 180, 60, 20, 50, 30, 90, 15, 35, 60,
                        60, 90, 180, 10, 5, 8, 300, 30, 45, 60, 45};
   int grav_tab[27] = '{0, -1311, -655, -1966, -655, -2621, 655, 1311, 328, 3277, -1311,
                        0, 0, 1966, 655, -1966, 1311, -655, 983, 0, 0, 0, 0, -1311,
                        -1311, 5243, 3932};

   bit          enabled = 1;
   int          cap = 64;
   int          live_count = 0;
   bit          live[64];
   logic [4:0]  kind[64];
   int          age[64];
   int          life[64];
   logic [31:0] pos[64][3];
   int          vel[64][3];
   logic [7:0]  alpha[64];
   logic [3:0]  frame[64];
   particle_report_type owed[$];
   int          errors = 0;

   function void set_register(logic [0:0] idx, logic [6:0] value);
      if (idx == ppu_pkg::CSR_ENABLE) enabled = value[0];
      else cap = int'(value);
   endfunction

   function int table_of(logic [4:0] k);
      return (k < 27) ? int'(k) : 0;
   endfunction

   // Velocity times 64225/65536, rounded toward minus infinity.
   function int apply_drag(int v);
      longint p;
      p = longint'(v) * 64225;
      return int'(p >>> 16);
   endfunction

   // Notes one accepted request and queues the reports it causes.
   function void note_request(logic typ, logic [4:0] k, logic [31:0] px, logic [31:0] py,
                              logic [31:0] pz, logic [23:0] vx, logic [23:0] vy,
                              logic [23:0] vz);
      particle_report_type r;
      int t, v, n, last_idx;
      r = '{default: '0};
      r.spawn_reply = 1;
      r.last = 1;
      if (typ == ppu_pkg::REQ_SPAWN) begin
         if (enabled && live_count < cap) begin
            for (int s = 0; s < 64; s++) begin
               if (!live[s]) begin
                  t = table_of(k);
                  live[s] = 1;
                  kind[s] = k;
                  age[s] = 0;
                  life[s] = life_tab[t];
                  pos[s][0] = px; pos[s][1] = py; pos[s][2] = pz;
                  vel[s][0] = int'(signed'(vx));
                  vel[s][1] = int'(signed'(vy));
                  vel[s][2] = int'(signed'(vz));
                  alpha[s] = 8'd255;
                  frame[s] = 4'd0;
                  live_count++;
                  r.slot = 6'(s); r.kind = k; r.x = px; r.y = py; r.z = pz;
                  r.alpha = 8'd255; r.ok = 1;
                  break;
               end
            end
         end
         owed.push_back(r);
         return;
      end
      if (!enabled) return;
      n = 0;
      for (int s = 0; s < 64; s++) begin
         if (!live[s]) continue;
         age[s] = (age[s] + 1) & 9'h1FF;
         if (age[s] >= life[s]) begin
            live[s] = 0;
            live_count--;
            continue;
         end
         t = table_of(kind[s]);
         v = vel[s][1] + grav_tab[t];
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         vel[s][1] = v;
         for (int j = 0; j < 3; j++) begin
            vel[s][j] = apply_drag(vel[s][j]);
            pos[s][j] = pos[s][j] + 32'(vel[s][j]);
         end
         if (10 * age[s] > 7 * life[s])
            alpha[s] = 8'((850 * (life[s] - age[s])) / life[s]);
         if (frames_tab[t] > 1)
            frame[s] = 4'((age[s] / 4) % frames_tab[t]);
         r = '{default: '0};
         r.slot = 6'(s); r.kind = kind[s];
         r.x = pos[s][0]; r.y = pos[s][1]; r.z = pos[s][2];
         r.alpha = alpha[s]; r.frame = frame[s];
         owed.push_back(r);
         n++;
      end
      if (n > 0) begin
         last_idx = owed.size() - 1;
         owed[last_idx].last = 1;
      end
   endfunction

   // Compares one accepted result with the oldest owed report.
   function void check_report(particle_report_type got);
      particle_report_type want;
      if (owed.size() == 0) begin
         $error("unexpected result transaction, slot %0d", got.slot);
         errors++;
         return;
      end
      want = owed.pop_front();
      if (got.slot !== want.slot) begin
         $error("slot: expected %0d, got %0d", want.slot, got.slot); errors++;
      end
      if (got.kind !== want.kind) begin
         $error("kind_out: expected %0d, got %0d", want.kind, got.kind); errors++;
      end
      if (got.x !== want.x) begin
         $error("out_x: expected %h, got %h", want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
         $error("out_y: expected %h, got %h", want.y, got.y); errors++;
      end
      if (got.z !== want.z) begin
         $error("out_z: expected %h, got %h", want.z, got.z); errors++;
      end
      if (got.alpha !== want.alpha) begin
         $error("alpha: expected %0d, got %0d", want.alpha, got.alpha); errors++;
      end
      if (got.frame !== want.frame) begin
         $error("frame: expected %0d, got %0d", want.frame, got.frame); errors++;
      end
      if (got.ok !== want.ok) begin
         $error("spawn_ok: expected %0d, got %0d", want.ok, got.ok); errors++;
      end
      if (got.spawn_reply !== want.spawn_reply) begin
         $error("is_spawn_reply: expected %0d, got %0d", want.spawn_reply,
                got.spawn_reply);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last); errors++;
      end
   endfunction
endclass

module tb_particle_pool_update_unit;
   // A quiet stretch beyond this limit, longer than a tick over a full pool
   // plus the long receiver hold, means a hang.
   localparam int QUIET_LIMIT = 20000;
   // Settle time before a register write: a tick that reports nothing may
   // still be walking the pool after the last result has arrived.
   localparam int SETTLE_CYCLES = 2000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [0:0]   req_tuser = '0;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [1:0]   rsp_tuser;
   logic [119:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic [0:0]   csr_index = '0;
   logic [6:0]   csr_wdata = '0;

   particle_pool_scoreboard pool_sb = new();

   int burst_left = 0;
   int report_count = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit calm_receiver = 0;

   particle_pool_update_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: checks every result transaction against the scoreboard and
   // stalls on its own pattern. Once, after the 100th result, it holds off
   // for a long stretch so that the block backs up into its input queue.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         particle_report_type got;
         got.slot = rsp_tdata[5:0];
         got.kind = rsp_tdata[10:6];
         got.x = rsp_tdata[42:11];
         got.y = rsp_tdata[74:43];
         got.z = rsp_tdata[106:75];
         got.alpha = rsp_tdata[114:107];
         got.frame = rsp_tdata[118:115];
         got.ok = rsp_tuser[0];
         got.spawn_reply = rsp_tuser[1];
         got.last = rsp_tlast;
         pool_sb.check_report(got);
         report_count++;
         if (report_count == 100) hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         // Flip between a calm mode and a stalling mode now and then.
         if ($urandom_range(0, 63) == 0) calm_receiver = ~calm_receiver;
         rsp_tready <= calm_receiver ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // Watchdog: counts cycles in which no transaction of any kind happens.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one request and waits for its transaction. The sender works in
   // bursts; valid is lowered only when a gap actually follows.
   task automatic send_request(logic typ, logic [4:0] k, logic [31:0] px,
                               logic [31:0] py, logic [31:0] pz, logic [23:0] vx,
                               logic [23:0] vy, logic [23:0] vz);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= typ;
      req_tdata <= {3'b000, vz, vy, vx, pz, py, px, k};
      do @(posedge clock); while (!req_tready);
      pool_sb.note_request(typ, k, px, py, pz, vx, vy, vz);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic spawn(logic [4:0] k, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                        logic [23:0] vx, logic [23:0] vy, logic [23:0] vz);
      send_request(ppu_pkg::REQ_SPAWN, k, px, py, pz, vx, vy, vz);
   endtask

   // A tick carries random payload, which the block must ignore.
   task automatic tick();
      send_request(ppu_pkg::REQ_TICK, 5'($urandom), $urandom, $urandom, $urandom,
                   24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   // Waits until the block is idle, then writes one register.
   task automatic write_register(logic [0:0] idx, logic [6:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pool_sb.owed.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pool_sb.set_register(idx, value);
   endtask

   function automatic logic [31:0] random_position();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 255)) << 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] random_velocity();
      logic [23:0] v;
      case ($urandom_range(0, 7))
         0: v = 24'h7F_FFFF;
         1: v = 24'h80_0000;
         2, 3: v = 24'($urandom);
         default: begin
            v = 24'($urandom_range(0, 24'h3_FFFF));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // A random phase: mostly spawns and ticks mixed, with random content.
   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 55)
            spawn(5'($urandom), random_position(), random_position(), random_position(),
                  random_velocity(), random_velocity(), random_velocity());
         else
            tick();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes, kinds beyond the table, a kind with zero
      // lifetime, saturating vy in both directions, wrapping positions, the
      // late-life fade, and long frame cycles.
      spawn(5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 24'h7F_FFFF, 24'h80_0000, 24'h0);
      spawn(5'd31, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 24'h80_0000, 24'hFF_FFFF,
            24'h7F_FFFF);
      spawn(5'd26, 32'h7FFF_0000, 32'h0001_0000, 32'h8000_0000, 24'h7F_FFFF,
            24'h7F_FFFF, 24'h80_0000);
      spawn(5'd5, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 24'h0, 24'h80_0000, 24'h00_0001);
      spawn(5'd20, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 24'hFF_FFFE, 24'h00_1000,
            24'h55_AAAA);
      spawn(5'd2, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 24'h2A_5555, 24'hD5_AAAA, 24'h0);
      spawn(5'd27, 32'h0, 32'h0, 32'h0, 24'h0, 24'h0, 24'h0);
      repeat (8) tick();

      // Cap of zero refuses every spawn.
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd0);
      spawn(5'd7, $urandom, $urandom, $urandom, 24'h1, 24'h2, 24'h3);
      tick();
      // Disabled: ticks do nothing and spawns are refused.
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd64);
      write_register(ppu_pkg::CSR_ENABLE, 7'd0);
      spawn(5'd1, $urandom, $urandom, $urandom, 24'h1, 24'h2, 24'h3);
      tick();
      tick();
      write_register(ppu_pkg::CSR_ENABLE, 7'd1);
      tick();

      // Pool full with the cap above the pool size: short-lived particles fill the
      // pool, then refusals, then ticks until those have all died.
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd127);
      repeat (10) tick();
      for (int i = 0; i < 66; i++)
         spawn(5'd20, random_position(), random_position(), random_position(),
               random_velocity(), random_velocity(), random_velocity());
      repeat (6) tick();

      // Random phases under several settings.
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd64);
      random_phase(80);
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd5);
      random_phase(40);
      write_register(ppu_pkg::CSR_ENABLE, 7'd0);
      random_phase(15);
      write_register(ppu_pkg::CSR_ENABLE, 7'd1);
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd127);
      random_phase(70);
      write_register(ppu_pkg::CSR_MAX_ACTIVE, 7'd64);
      random_phase(45);

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pool_sb.owed.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pool_sb.owed.size() != 0) begin
         $error("%0d expected result transactions never arrived", pool_sb.owed.size());
         pool_sb.errors++;
      end
      if (pool_sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
